// File: sv/gsu_pkg.sv
// Package with shared widths, codes and structs of the sub-block code unpacker.
`default_nettype none
package gsu_pkg;

  localparam int unsigned BUF_BITS  = 24;
  localparam int unsigned BYTE_BITS = 8;
  localparam int unsigned MAX_CODE  = 16;
  localparam int unsigned CNT_W     = 5;
  localparam int unsigned BLK_W     = 8;
  localparam int unsigned SIZE_W    = 5;
  localparam int unsigned CODE_W    = 16;
  localparam int unsigned STATUS_W  = 2;

  typedef enum logic [STATUS_W-1:0] {
    ST_CODE    = 2'd0,
    ST_END     = 2'd1,
    ST_REFUSED = 2'd2,
    ST_DROPPED = 2'd3
  } status_t;

  typedef enum logic {
    KIND_BYTE    = 1'b0,
    KIND_REQUEST = 1'b1
  } kind_t;

  typedef struct packed {
    logic              kind;
    logic [BLK_W-1:0]  data_byte;
    logic [SIZE_W-1:0] code_size;
  } item_t;

  typedef struct packed {
    logic              valid;
    logic [CODE_W-1:0] code;
    status_t           status;
  } result_t;

endpackage
`default_nettype wire

// File: sv/gsu_in_if.sv
// Input channel interface carrying raw stream bytes and code requests.
`default_nettype none
interface gsu_in_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [gsu_pkg::BLK_W-1:0]   data_byte;
  logic [gsu_pkg::SIZE_W-1:0]  code_size;

  modport source (output valid, kind, data_byte, code_size, input ready);
  modport sink   (input valid, kind, data_byte, code_size, output ready);
endinterface
`default_nettype wire

// File: sv/gsu_out_if.sv
// Result channel interface carrying codes and status.
`default_nettype none
interface gsu_out_if;
  logic                          valid;
  logic                          ready;
  logic [gsu_pkg::CODE_W-1:0]    code;
  logic [gsu_pkg::STATUS_W-1:0]  status;

  modport source (output valid, code, status, input ready);
  modport sink   (input valid, code, status, output ready);
endinterface
`default_nettype wire

// File: sv/gif_subblock_code_unpacker.sv
// Top level of the sub-block code unpacker.
// The input channel in_ch carries one item per transfer: either a raw stream
// byte (kind 0, data_byte) or a request for one code (kind 1, code_size).
// Length bytes open each sub-block and are consumed; data bytes fill a
// 24-bit buffer, least significant bit first. The result channel out_ch
// carries a code with status 0, or a status for end of data, a refused
// request or a dropped byte. Not every item causes a result.
// An accepted item is held in the input register while the buffer logic
// processes it, and its result is then loaded into the output register,
// from which it is offered on out_ch.
// One item can be accepted in every cycle unless a stalled receiver holds
// back a result; the buffer update is the single step that sets this rate.
// A synchronous active-low reset empties both registers, clears the buffer
// and the pending request, and makes the next byte a length byte.
// When the receiver stalls, the output register holds its result and the
// input register keeps taking items that cause no result; an item with a
// result waits in the input register, and then in_ch.ready falls.
`default_nettype none
module gif_subblock_code_unpacker (
  input  wire logic clk,
  input  wire logic rst_n,
  gsu_in_if.sink    in_ch,
  gsu_out_if.source out_ch
);
  import gsu_pkg::*;

  logic    stg_valid_r;
  item_t   stg_item_r;
  result_t res;
  logic    advance;

  logic                out_valid_r;
  logic [CODE_W-1:0]   out_code_r;
  logic [STATUS_W-1:0] out_status_r;

  gsu_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .item    (stg_item_r),
    .res     (res)
  );

  assign advance     = stg_valid_r && (!res.valid || !out_valid_r || out_ch.ready);
  assign in_ch.ready = !stg_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      stg_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      stg_item_r.kind      <= in_ch.kind;
      stg_item_r.data_byte <= in_ch.data_byte;
      stg_item_r.code_size <= in_ch.code_size;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && res.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      out_code_r   <= res.code;
      out_status_r <= res.status;
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.code   = out_code_r;
  assign out_ch.status = out_status_r;

endmodule
`default_nettype wire

// File: sv/gsu_core.sv
// Bit buffer, sub-block tracking and request logic of the code unpacker.
`default_nettype none
module gsu_core (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             step_en,
  input  wire gsu_pkg::item_t   item,
  output gsu_pkg::result_t      res
);
  import gsu_pkg::*;

  logic [BUF_BITS-1:0] buf_r, buf_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [BLK_W-1:0]    rem_r, rem_nxt;
  logic [SIZE_W-1:0]   pend_r, pend_nxt;

  always_comb begin
    logic [BUF_BITS-1:0] work_buf;
    logic [CNT_W-1:0]    work_cnt;
    logic [SIZE_W-1:0]   size_sat;
    logic [SIZE_W-1:0]   take_w;
    logic                take_en;
    logic [BUF_BITS-1:0] mask;

    work_buf   = buf_r;
    work_cnt   = cnt_r;
    rem_nxt    = rem_r;
    pend_nxt   = pend_r;
    take_w     = '0;
    take_en    = 1'b0;
    res.valid  = 1'b0;
    res.code   = '0;
    res.status = ST_CODE;
    size_sat   = (item.code_size > SIZE_W'(MAX_CODE)) ? SIZE_W'(MAX_CODE) : item.code_size;

    if (item.kind == KIND_BYTE) begin
      if (rem_r == '0) begin
        if (item.data_byte == '0) begin
          res.valid  = 1'b1;
          res.status = ST_END;
        end else begin
          rem_nxt = item.data_byte;
        end
      end else begin
        rem_nxt = rem_r - BLK_W'(1);
        if (cnt_r > CNT_W'(BUF_BITS - BYTE_BITS)) begin
          res.valid  = 1'b1;
          res.status = ST_DROPPED;
        end else begin
          work_buf = buf_r | (BUF_BITS'(item.data_byte) << cnt_r);
          work_cnt = cnt_r + CNT_W'(BYTE_BITS);
          if (pend_r != '0 && work_cnt >= CNT_W'(pend_r)) begin
            take_en  = 1'b1;
            take_w   = pend_r;
            pend_nxt = '0;
          end
        end
      end
    end else begin
      if (pend_r != '0) begin
        res.valid  = 1'b1;
        res.status = ST_REFUSED;
      end else if (size_sat == '0) begin
        res.valid = 1'b1;
      end else if (cnt_r >= CNT_W'(size_sat)) begin
        take_en = 1'b1;
        take_w  = size_sat;
      end else begin
        pend_nxt = size_sat;
      end
    end

    mask = (BUF_BITS'(1) << take_w) - BUF_BITS'(1);
    if (take_en) begin
      res.valid  = 1'b1;
      res.status = ST_CODE;
      res.code   = CODE_W'(work_buf & mask);
      buf_nxt    = work_buf >> take_w;
      cnt_nxt    = work_cnt - CNT_W'(take_w);
    end else begin
      buf_nxt = work_buf;
      cnt_nxt = work_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_r  <= '0;
      cnt_r  <= '0;
      rem_r  <= '0;
      pend_r <= '0;
    end else if (step_en) begin
      buf_r  <= buf_nxt;
      cnt_r  <= cnt_nxt;
      rem_r  <= rem_nxt;
      pend_r <= pend_nxt;
    end
  end

endmodule
`default_nettype wire
